// ----- rtl/uida_pkg.sv -----
// ----------------------------------------------------------------------------
// uida_pkg
// Shared constants and types of the unique ID allocator: bitmap geometry,
// operation codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package uida_pkg;

    localparam int NUM_IDS  = 4096;
    localparam int FIELD_W  = 12;
    localparam int ID_W     = $clog2(NUM_IDS);
    localparam int PTR_W    = ID_W + 1;
    localparam int NX_W     = PTR_W + 1;
    localparam int ROW_W    = 32;
    localparam int OFF_W    = $clog2(ROW_W);
    localparam int NUM_ROWS = (NUM_IDS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CMP_W    = ((FIELD_W > PTR_W) ? FIELD_W : PTR_W) + 1;

    typedef enum logic [0:0] {
        OP_MARK   = 1'b0,
        OP_ASSIGN = 1'b1
    } t_op;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_more;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/uida_ram.sv -----
// ----------------------------------------------------------------------------
// uida_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/uida_ctrl.sv -----
// ----------------------------------------------------------------------------
// uida_ctrl
// Controller: accepts one transfer, walks the bitmap rows while an assign
// scan continues, and retires the result once the output register is free.
// ----------------------------------------------------------------------------
module uida_ctrl
    import uida_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.scan_more) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    a_load_enters_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EVAL))
        else $error("load did not enter evaluation");

endmodule

// ----- rtl/uida_dp.sv -----
// ----------------------------------------------------------------------------
// uida_dp
// Datapath: bitmap RAM of 32-bit rows with per-row valid bits, scan pointer,
// first-clear-bit search over one row and the output register.
// ----------------------------------------------------------------------------
module uida_dp
    import uida_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [0:0]         i_op,
    input  logic [FIELD_W-1:0] i_index,
    input  logic               i_stall,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_valid,
    output logic               o_was_used,
    output logic [FIELD_W-1:0] o_assigned_id,
    output logic               o_exhausted
);

    t_op                r_op;
    logic [FIELD_W-1:0] r_index;
    logic               r_in_range;
    logic [ROW_AW-1:0]  r_row;
    logic [PTR_W-1:0]   r_ptr;
    logic [NUM_ROWS-1:0] r_row_vld;
    logic               r_o_valid;
    logic               r_was_used;
    logic [FIELD_W-1:0] r_assigned_id;
    logic               r_exhausted;

    logic [ROW_W-1:0]   ram_q;
    logic [ROW_W-1:0]   row_data;
    logic [ROW_W-1:0]   cand;
    logic [ROW_W-1:0]   new_row;
    logic [ROW_W-1:0]   mark_bit;
    logic [OFF_W-1:0]   mark_off;
    logic [OFF_W-1:0]   ptr_off;
    logic [OFF_W-1:0]   fbit;
    logic               found;
    logic [NX_W-1:0]    found_id;
    logic [NX_W-1:0]    next_start;
    logic               ptr_end;
    logic               hit;
    logic               next_end;
    logic               exh;
    logic               we;
    logic               re;
    logic [ROW_AW-1:0]  raddr;
    logic [ROW_AW-1:0]  ptr_row;
    logic               in_range;
    logic               out_free;

    assign ptr_row  = ROW_AW'(r_ptr >> OFF_W);
    assign in_range = CMP_W'(i_index) < CMP_W'(NUM_IDS);

    always_comb begin
        raddr = r_row + ROW_AW'(1);
        if (i_cmd.load) begin
            raddr = (t_op'(i_op) == OP_MARK) ? ROW_AW'(i_index >> OFF_W) : ptr_row;
        end
    end

    assign re = i_cmd.load | i_cmd.step;

    uida_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_row),
        .i_wdata (new_row),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign row_data = r_row_vld[r_row] ? ram_q : '0;
    assign mark_off = r_index[OFF_W-1:0];
    assign ptr_off  = r_ptr[OFF_W-1:0];
    assign cand     = ~row_data & ({ROW_W{1'b1}} << ptr_off);

    always_comb begin
        found = 1'b0;
        fbit  = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                found = 1'b1;
                fbit  = OFF_W'(b);
            end
        end
    end

    assign found_id   = (NX_W'(r_row) << OFF_W) | NX_W'(fbit);
    assign next_start = (NX_W'(r_row) + NX_W'(1)) << OFF_W;
    assign ptr_end    = NX_W'(r_ptr) >= NX_W'(NUM_IDS);
    assign hit        = !ptr_end && found && (found_id < NX_W'(NUM_IDS));
    assign next_end   = next_start >= NX_W'(NUM_IDS);
    assign exh        = !hit;

    assign mark_bit = ROW_W'(1) << mark_off;

    always_comb begin
        if (r_op == OP_MARK) begin
            new_row = row_data | mark_bit;
            we      = i_cmd.finish && r_in_range;
        end else begin
            new_row = row_data | (ROW_W'(1) << fbit);
            we      = i_cmd.finish && hit;
        end
    end

    assign out_free        = !r_o_valid || !i_stall;
    assign o_sts.out_free  = out_free;
    assign o_sts.scan_more = (r_op == OP_ASSIGN) && !ptr_end && !found && !next_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_op);
            r_index    <= i_index;
            r_in_range <= in_range;
            r_row      <= raddr;
        end else if (i_cmd.step) begin
            r_row <= raddr;
        end
        if (i_cmd.finish) begin
            if (r_op == OP_MARK) begin
                r_was_used    <= r_in_range && row_data[mark_off];
                r_assigned_id <= '0;
                r_exhausted   <= 1'b0;
            end else begin
                r_was_used    <= 1'b0;
                r_assigned_id <= hit ? FIELD_W'(found_id) : '0;
                r_exhausted   <= exh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_row_vld <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_ptr <= PTR_W'(next_start);
            end else if (i_cmd.finish && r_op == OP_ASSIGN) begin
                r_ptr <= hit ? PTR_W'(found_id + NX_W'(1)) : PTR_W'(NUM_IDS);
            end
            if (we) begin
                r_row_vld[r_row] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_was_used    = r_was_used;
    assign o_assigned_id = r_assigned_id;
    assign o_exhausted   = r_exhausted;

    a_ptr_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_ptr >= $past(r_ptr)))
        else $error("scan pointer moved backward");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NX_W'(r_ptr) <= NX_W'(NUM_IDS))
        else $error("scan pointer beyond last ID");

    a_assign_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_op == OP_ASSIGN && hit) |-> we)
        else $error("allocated ID not recorded in bitmap");

    a_exh_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_exhausted) |-> (r_assigned_id == '0 && !r_was_used))
        else $error("exhausted result carries an ID");

endmodule

// ----- rtl/unique_id_allocator_core.sv -----
// ----------------------------------------------------------------------------
// unique_id_allocator_core
// Next-fit ID allocator over a used-bitmap with a forward-only scan pointer.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   input   | i_valid / o_stall  | i_op, i_index
//   output  | o_valid / i_stall  | o_was_used, o_assigned_id, o_exhausted
//
// A mark reads its bitmap row and finishes with a read-modify-write of it;
// an assign also steps through each further 32-ID bitmap row it skips.
// A new transfer is taken only once the previous one has finished (o_stall).
// Reset clears 128 row valid bits at once; no clearing pass is needed.
// A finished result waits in the output register while a new transfer is
// taken; evaluation holds only if that register is still stalled.
// ----------------------------------------------------------------------------
module unique_id_allocator_core
    import uida_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [0:0]         i_op,
    input  logic [FIELD_W-1:0] i_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_was_used,
    output logic [FIELD_W-1:0] o_assigned_id,
    output logic               o_exhausted
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    uida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    uida_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_index       (i_index),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_was_used    (o_was_used),
        .o_assigned_id (o_assigned_id),
        .o_exhausted   (o_exhausted)
    );

endmodule
